// ===== rtl/core/rssi_pkg.sv =====
`timescale 1ns / 1ps

package rssi_pkg;

    localparam int LOG_DEPTH = 16;
    localparam int HEAD_W    = $clog2(LOG_DEPTH);
    localparam int FILL_W    = $clog2(LOG_DEPTH + 1);
    localparam int POS_W     = HEAD_W + 1;

    localparam logic [6:0]  THRESHOLD_MIN   = 7'd5;
    localparam logic [6:0]  THRESHOLD_MAX   = 7'd80;
    localparam logic [6:0]  THRESHOLD_RESET = 7'd25;
    localparam logic [15:0] INTERVAL_RESET  = 16'd80;
    localparam logic [15:0] OPEN_RESET      = 16'd2000;
    localparam logic [15:0] CLOSE_RESET     = 16'd5000;

    typedef enum logic [2:0] {
        CMD_SAMPLE = 3'd0,
        CMD_READ   = 3'd1,
        CMD_CLEAR  = 3'd2,
        CMD_ARM    = 3'd3,
        CMD_DISARM = 3'd4,
        CMD_START  = 3'd5,
        CMD_STOP   = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_IGNORED = 3'd0,
        KIND_SAMPLED = 3'd1,
        KIND_OPENED  = 3'd2,
        KIND_CLOSED  = 3'd3,
        KIND_ENTRY   = 3'd4,
        KIND_EMPTY   = 3'd5,
        KIND_DONE    = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        REG_THRESHOLD = 3'd0,
        REG_INTERVAL  = 3'd1,
        REG_OPEN      = 3'd2,
        REG_CLOSE     = 3'd3
    } reg_index_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] now_ms;
        logic [7:0]  strength;
        logic [7:0]  noise_ratio;
        logic [15:0] tuned_khz;
        logic        upper_sideband;
        logic        am_mode;
        logic [7:0]  entry_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] event_khz;
        logic        event_usb;
        logic        event_am;
        logic [7:0]  event_peak_strength;
        logic [7:0]  event_peak_noise_ratio;
        logic [4:0]  log_count;
    } out_item_t;

    typedef struct packed {
        logic [15:0] khz;
        logic        usb;
        logic        am;
    } event_mode_t;

    typedef struct packed {
        event_mode_t mode;
        logic [7:0]  pk_str;
        logic [7:0]  pk_snr;
    } log_entry_t;

endpackage

// ===== rtl/core/rssi_event_detector_logger_core.sv =====
`timescale 1ns / 1ps

// Signal presence detector and event logger. Items enter an input register and are
// resolved in a single pass of compare and select logic into a result register, so
// one item is taken every clock cycle and its result is held in the result register;
// the throughput is limited only by the result register being stalled. The ring log
// of LOG_DEPTH entries lives in flip-flops without reset, and an entry is read by
// entry_index, 0 being the newest. Configuration writes take effect at the next clock
// edge and must be made while no item is in flight.
module rssi_event_detector_logger_core
    import rssi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // configuration
    logic [6:0]  threshold_reg;
    logic [15:0] interval_reg;
    logic [15:0] open_delay_reg;
    logic [15:0] close_delay_reg;
    logic [6:0]  threshold_wr;

    // pipeline
    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    out_item_t   out_item_next;
    logic        advance;
    logic        fire;

    // detector state
    logic        active_reg,  active_next;
    logic        armed_reg,   armed_next;
    logic        open_reg,    open_next;
    logic [31:0] above_reg,   above_next;
    logic [31:0] below_reg,   below_next;
    logic [31:0] last_reg,    last_next;
    logic [7:0]  pk_str_reg,  pk_str_next;
    logic [7:0]  pk_snr_reg,  pk_snr_next;
    event_mode_t cur_reg,     cur_next;
    logic [HEAD_W-1:0] head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    // log store
    log_entry_t  log_mem [LOG_DEPTH];
    logic        log_we;
    log_entry_t  log_wdata;
    logic [POS_W-1:0]  pos_sum;
    logic [HEAD_W-1:0] rd_pos;
    log_entry_t  rd_entry;

    // sample path
    logic [31:0] since_last;
    logic        sample_ok;
    logic        present;
    logic [31:0] above_eff;
    logic [31:0] below_eff;
    logic [8:0]  idx_ext;
    logic [8:0]  fill_ext;

    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        threshold_wr = cfg_data[6:0];
        if (threshold_wr < THRESHOLD_MIN)
        begin
            threshold_wr = THRESHOLD_MIN;
        end
        else if (threshold_wr > THRESHOLD_MAX)
        begin
            threshold_wr = THRESHOLD_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= THRESHOLD_RESET;
            interval_reg    <= INTERVAL_RESET;
            open_delay_reg  <= OPEN_RESET;
            close_delay_reg <= CLOSE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_THRESHOLD: threshold_reg   <= threshold_wr;
                REG_INTERVAL:  interval_reg    <= cfg_data;
                REG_OPEN:      open_delay_reg  <= cfg_data;
                REG_CLOSE:     close_delay_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // newest-first position in the ring
    assign pos_sum  = {1'b0, head_reg} + POS_W'(LOG_DEPTH - 1)
                      - {1'b0, in_item_reg.entry_index[HEAD_W-1:0]};
    assign rd_pos   = (pos_sum >= POS_W'(LOG_DEPTH)) ? HEAD_W'(pos_sum - POS_W'(LOG_DEPTH))
                                                     : pos_sum[HEAD_W-1:0];
    assign rd_entry = log_mem[rd_pos];
    assign idx_ext  = {1'b0, in_item_reg.entry_index};
    assign fill_ext = 9'(fill_reg);

    assign since_last = in_item_reg.now_ms - last_reg;
    assign sample_ok  = active_reg && armed_reg && !(since_last < {16'b0, interval_reg});
    assign present    = in_item_reg.strength >= {1'b0, threshold_reg};
    assign above_eff  = (above_reg == 32'd0) ? in_item_reg.now_ms : above_reg;
    assign below_eff  = (below_reg == 32'd0) ? in_item_reg.now_ms : below_reg;

    always_comb
    begin
        active_next   = active_reg;
        armed_next    = armed_reg;
        open_next     = open_reg;
        above_next    = above_reg;
        below_next    = below_reg;
        last_next     = last_reg;
        pk_str_next   = pk_str_reg;
        pk_snr_next   = pk_snr_reg;
        cur_next      = cur_reg;
        head_next     = head_reg;
        fill_next     = fill_reg;
        log_we        = 1'b0;
        log_wdata     = '{mode: cur_reg, pk_str: pk_str_reg, pk_snr: pk_snr_reg};
        out_item_next = '0;
        out_item_next.kind = KIND_DONE;

        if (fire)
        begin
            case (in_item_reg.command)
                CMD_SAMPLE:
                begin
                    if (!sample_ok)
                    begin
                        out_item_next.kind = KIND_IGNORED;
                    end
                    else
                    begin
                        out_item_next.kind = KIND_SAMPLED;
                        last_next = in_item_reg.now_ms;
                        if (present)
                        begin
                            below_next = 32'd0;
                            above_next = above_eff;
                            if (in_item_reg.strength > pk_str_reg)
                            begin
                                pk_str_next = in_item_reg.strength;
                            end
                            if (in_item_reg.noise_ratio > pk_snr_reg)
                            begin
                                pk_snr_next = in_item_reg.noise_ratio;
                            end
                            if (!open_reg && ((in_item_reg.now_ms - above_eff)
                                              >= {16'b0, open_delay_reg}))
                            begin
                                open_next          = 1'b1;
                                cur_next.khz       = in_item_reg.tuned_khz;
                                cur_next.usb       = in_item_reg.upper_sideband;
                                cur_next.am        = in_item_reg.am_mode;
                                out_item_next.kind = KIND_OPENED;
                            end
                        end
                        else
                        begin
                            above_next = 32'd0;
                            below_next = below_eff;
                            if (open_reg && ((in_item_reg.now_ms - below_eff)
                                             >= {16'b0, close_delay_reg}))
                            begin
                                log_we      = 1'b1;
                                head_next   = (head_reg == HEAD_W'(LOG_DEPTH - 1))
                                              ? '0 : head_reg + 1'b1;
                                if (fill_reg < FILL_W'(LOG_DEPTH))
                                begin
                                    fill_next = fill_reg + 1'b1;
                                end
                                open_next   = 1'b0;
                                pk_str_next = 8'd0;
                                pk_snr_next = 8'd0;
                                out_item_next.kind                   = KIND_CLOSED;
                                out_item_next.event_khz              = cur_reg.khz;
                                out_item_next.event_usb              = cur_reg.usb;
                                out_item_next.event_am               = cur_reg.am;
                                out_item_next.event_peak_strength    = pk_str_reg;
                                out_item_next.event_peak_noise_ratio = pk_snr_reg;
                            end
                        end
                    end
                end
                CMD_READ:
                begin
                    if (idx_ext >= fill_ext)
                    begin
                        out_item_next.kind = KIND_EMPTY;
                    end
                    else
                    begin
                        out_item_next.kind                   = KIND_ENTRY;
                        out_item_next.event_khz              = rd_entry.mode.khz;
                        out_item_next.event_usb              = rd_entry.mode.usb;
                        out_item_next.event_am               = rd_entry.mode.am;
                        out_item_next.event_peak_strength    = rd_entry.pk_str;
                        out_item_next.event_peak_noise_ratio = rd_entry.pk_snr;
                    end
                end
                CMD_CLEAR:
                begin
                    fill_next = '0;
                    head_next = '0;
                end
                CMD_ARM:
                begin
                    armed_next = 1'b1;
                    open_next  = 1'b0;
                    above_next = 32'd0;
                    below_next = 32'd0;
                end
                CMD_DISARM:
                begin
                    armed_next = 1'b0;
                    open_next  = 1'b0;
                    above_next = 32'd0;
                    below_next = 32'd0;
                end
                CMD_START:
                begin
                    active_next = 1'b1;
                    open_next   = 1'b0;
                    above_next  = 32'd0;
                    below_next  = 32'd0;
                    last_next   = 32'd0;
                end
                CMD_STOP:
                begin
                    open_next   = 1'b0;
                    active_next = 1'b0;
                    armed_next  = 1'b0;
                end
                default:
                begin
                    out_item_next.kind = KIND_IGNORED;
                end
            endcase
        end

        out_item_next.log_count = 5'(fill_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            armed_reg     <= 1'b0;
            open_reg      <= 1'b0;
            above_reg     <= 32'd0;
            below_reg     <= 32'd0;
            last_reg      <= 32'd0;
            pk_str_reg    <= 8'd0;
            pk_snr_reg    <= 8'd0;
            cur_reg       <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            active_reg <= active_next;
            armed_reg  <= armed_next;
            open_reg   <= open_next;
            above_reg  <= above_next;
            below_reg  <= below_next;
            last_reg   <= last_next;
            pk_str_reg <= pk_str_next;
            pk_snr_reg <= pk_snr_next;
            cur_reg    <= cur_next;
            head_reg   <= head_next;
            fill_reg   <= fill_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_item;
        end
        if (fire)
        begin
            out_item_reg <= out_item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (log_we)
        begin
            log_mem[head_reg] <= log_wdata;
        end
    end

endmodule
